// ===== sv/pbcc_pkg.sv =====
`default_nettype none
package pbcc_pkg;
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_READ = 2'd1,
        OP_ROW  = 2'd2,
        OP_NONE = 2'd3
    } t_op;
    localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] LIMIT_RESET = 16'd200;
    localparam logic [16:0] WEIGHT_ONE = 17'd256;
endpackage
`default_nettype wire

// ===== sv/pbcc_ram.sv =====
`default_nettype none
module pbcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/positional_base_composition_counter.sv =====
// Positional base composition counter. Load a reference one character per word
// (op 0), submit aligned reads (op 1) and read histogram rows (op 2); one result
// word per input word. The next word is accepted only after the previous result
// word has been taken. A read walks its clipped span plus up to FLANK bases on
// each side through one shared read-modify-write unit, base by base (reference
// read, histogram read, saturating add, write back). A row read does one
// histogram read per base. After reset the histogram is cleared by a pass over
// all 4*HIST_ROWS cells, one cell per cycle, during which no word is accepted.
`default_nettype none
module positional_base_composition_counter #(
    parameter int REF_DEPTH = 1048576,
    parameter int HIST_ROWS = 4096,
    parameter int FLANK     = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [19:0] i_address,
    input  wire logic [7:0]  i_symbol,
    input  wire logic [15:0] i_target_id,
    input  wire logic [19:0] i_start_pos,
    input  wire logic [19:0] i_end_pos,
    input  wire logic [20:0] i_target_length,
    input  wire logic        i_reverse,
    input  wire logic        i_unmapped,
    input  wire logic [15:0] i_weight,
    input  wire logic [15:0] i_query_length,
    input  wire logic [11:0] i_row_index,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [47:0]      o_count_a,
    output logic [47:0]      o_count_c,
    output logic [47:0]      o_count_t,
    output logic [47:0]      o_count_g,
    output logic [15:0]      o_read_length,
    output logic             o_warning,
    output logic [15:0]      o_warning_count,
    output logic [15:0]      o_warned_target,
    output logic [19:0]      o_warned_pos,
    output logic             o_skipped
);
    localparam int RAW  = $clog2(REF_DEPTH);
    localparam int RW   = $clog2(HIST_ROWS);
    localparam int HAW  = RW + 2;
    localparam int HD   = 4 * HIST_ROWS;
    localparam logic signed [23:0] FL  = 24'(FLANK);
    localparam logic signed [23:0] TOP = 24'(HIST_ROWS - 1 - FLANK);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOADW, S_SETUP, S_REF, S_HRD, S_ADD, S_WR,
        S_ROWRD, S_ROWCAP, S_OUT
    } t_state;

    t_state r_state;
    logic [HAW-1:0] r_clr;
    logic [15:0] r_limit;

    // latched word
    logic [19:0] r_addr, r_spos, r_epos;
    logic [20:0] r_tlen;
    logic        r_rev;
    logic [16:0] r_w;
    logic [1:0]  r_sym;
    logic [11:0] r_row;

    logic signed [23:0] r_i, r_hi;
    logic [1:0]  r_base;
    logic [47:0] r_cell;
    logic [1:0]  r_k;

    logic        r_run_valid;
    logic [15:0] r_run_target, r_run_count, r_len;
    logic [19:0] r_run_pos;
    logic        r_any;

    logic [47:0] r_cnt [4];

    // reference RAM
    logic          ref_we;
    logic [RAW-1:0] ref_waddr, ref_raddr;
    logic [1:0]    ref_rdata;
    // histogram RAM
    logic          h_we;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [47:0]   h_wdata, h_rdata;

    pbcc_ram #(.WIDTH(2), .DEPTH(REF_DEPTH)) u_ref (
        .i_clk(i_clk), .i_we(ref_we), .i_waddr(ref_waddr), .i_wdata(r_sym),
        .i_raddr(ref_raddr), .o_rdata(ref_rdata)
    );
    pbcc_ram #(.WIDTH(48), .DEPTH(HD)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    logic signed [23:0] s_pos, s_end, s_len;
    logic signed [23:0] ref_pos;
    logic [47:0] sum;
    logic [48:0] sum_w;
    logic [1:0]  cur_base;

    assign s_pos = 24'(r_spos);
    assign s_end = 24'(r_epos);
    assign s_len = 24'(r_tlen);
    assign ref_pos = r_rev ? (s_end - r_i) : (s_pos + r_i);
    assign ref_raddr = RAW'(24'(r_addr) + ref_pos);
    assign ref_we = (r_state == S_LOADW);
    assign ref_waddr = RAW'(r_addr);
    assign sum_w = 49'(r_cell) + 49'(r_w);
    assign sum = sum_w[48] ? pbcc_pkg::CNT_MAX : sum_w[47:0];
    // reverse reads count the complemented base
    assign cur_base = r_rev ? (ref_rdata ^ 2'd2) : ref_rdata;

    logic [RW-1:0] walk_row;
    assign walk_row = RW'(r_i + FL);

    always_comb begin
        h_we = 1'b0;
        h_waddr = r_clr;
        h_wdata = sum;
        h_raddr = {walk_row, r_base};
        unique case (r_state)
            S_CLEAR: begin
                h_we = 1'b1;
                h_wdata = '0;
            end
            S_HRD: h_raddr = {walk_row, cur_base};
            S_WR: begin
                h_we = 1'b1;
                h_waddr = {walk_row, r_base};
            end
            S_ROWRD: h_raddr = {RW'(r_row), r_k};
            // fetch the next cell while the current one is captured
            S_ROWCAP: h_raddr = {RW'(r_row), r_k + 2'd1};
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || o_valid;
    assign o_cfg_ready = 1'b1;

    logic accept;
    assign accept = i_valid && !o_stall;

    logic signed [23:0] lo_f, hi_f, lo_r, hi_r;
    always_comb begin
        lo_f = (s_pos >= FL) ? -FL : -s_pos;
        hi_f = (s_end + FL < s_len) ? (s_end - s_pos) + FL : s_len - s_pos - 24'sd1;
        lo_r = (s_end + FL < s_len) ? -FL : s_end - (s_len - 24'sd1);
        hi_r = (s_pos >= FL) ? (s_end - s_pos) + FL : s_end;
    end

    logic new_run;
    logic [15:0] cnt_next;
    always_comb begin
        new_run = !r_run_valid || (i_target_id != r_run_target) || (i_start_pos != r_run_pos);
        cnt_next = new_run ? 16'd1 : ((r_run_count == 16'hFFFF) ? r_run_count
                                                               : r_run_count + 16'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_limit <= pbcc_pkg::LIMIT_RESET;
            r_run_valid <= 1'b0;
            r_run_target <= '0;
            r_run_pos <= '0;
            r_run_count <= '0;
            r_len <= '0;
            r_any <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HAW'(HD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr <= i_address;
                        r_spos <= i_start_pos;
                        r_epos <= i_end_pos;
                        r_tlen <= i_target_length;
                        r_rev <= i_reverse;
                        r_w <= (i_weight == '0) ? pbcc_pkg::WEIGHT_ONE : 17'(i_weight);
                        r_sym <= i_symbol[2:1];
                        r_row <= i_row_index;
                        r_k <= '0;
                        o_count_a <= '0;
                        o_count_c <= '0;
                        o_count_t <= '0;
                        o_count_g <= '0;
                        o_warning <= 1'b0;
                        o_warning_count <= '0;
                        o_warned_target <= '0;
                        o_warned_pos <= '0;
                        o_skipped <= 1'b0;
                        unique case (pbcc_pkg::t_op'(i_op))
                            pbcc_pkg::OP_LOAD: r_state <= S_LOADW;
                            pbcc_pkg::OP_READ: begin
                                if (!r_any) begin
                                    r_len <= i_query_length;
                                end
                                if (i_unmapped) begin
                                    o_skipped <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    if (new_run && r_run_valid && r_run_count >= r_limit) begin
                                        o_warning <= 1'b1;
                                        o_warning_count <= r_run_count;
                                        o_warned_target <= r_run_target;
                                        o_warned_pos <= r_run_pos;
                                    end
                                    r_run_valid <= 1'b1;
                                    r_run_target <= i_target_id;
                                    r_run_pos <= i_start_pos;
                                    r_run_count <= cnt_next;
                                    if (cnt_next >= r_limit) begin
                                        o_skipped <= 1'b1;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_any <= 1'b1;
                                        r_state <= S_SETUP;
                                    end
                                end
                            end
                            pbcc_pkg::OP_ROW: begin
                                r_state <= (32'(i_row_index) < HIST_ROWS) ? S_ROWRD : S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_LOADW: r_state <= S_OUT;
                S_SETUP: begin
                    r_i <= r_rev ? lo_r : lo_f;
                    r_hi <= ((r_rev ? hi_r : hi_f) > TOP) ? TOP : (r_rev ? hi_r : hi_f);
                    r_state <= S_REF;
                end
                S_REF: begin
                    // stop past the end, or where a reverse walk runs below zero
                    if (r_i > r_hi || (r_rev && ref_pos < 0)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_base <= cur_base;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_cell <= h_rdata;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_i <= r_i + 24'sd1;
                    r_state <= S_REF;
                end
                S_ROWRD: r_state <= S_ROWCAP;
                S_ROWCAP: begin
                    r_cnt[r_k] <= h_rdata;
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        o_count_a <= r_cnt[0];
                        o_count_c <= r_cnt[1];
                        o_count_t <= r_cnt[2];
                        o_count_g <= h_rdata;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_read_length <= r_len;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/pbcc_checker.sv =====
`default_nettype none
module pbcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_warning,
    input wire logic [15:0] o_warning_count,
    input wire logic        o_skipped,
    input wire logic [47:0] o_count_a
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_count_a))
        else $error("stalled word changed");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted while busy");
    a_wcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_warning |-> o_warning_count != 16'd0)
        else $error("warning with zero count");
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skipped |-> o_count_a == 48'd0)
        else $error("skipped word carries counts");
endmodule

bind positional_base_composition_counter pbcc_checker u_pbcc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_warning(o_warning),
    .o_warning_count(o_warning_count), .o_skipped(o_skipped), .o_count_a(o_count_a)
);
`default_nettype wire
